// File: rtl/core/terminal_key_byte_decoder_defines.svh
// ----------------------------------------------------------------------------
// terminal key byte decoder assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_BYTE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_BYTE_DECODER_DEFINES_SVH

// condition holds at every edge out of reset
`define TKBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TKBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TKBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tkbd_pkg.sv
// ----------------------------------------------------------------------------
// tkbd_pkg
// key codes, byte constants and item types of the terminal key byte decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkbd_pkg;

  typedef enum logic [4:0] {
    K_NONE      = 5'd0,
    K_CHAR      = 5'd1,
    K_ENTER     = 5'd2,
    K_BACKSPACE = 5'd3,
    K_INTERRUPT = 5'd4,
    K_EOF       = 5'd5,
    K_HOME      = 5'd6,
    K_END       = 5'd7,
    K_LEFT      = 5'd8,
    K_RIGHT     = 5'd9,
    K_UP        = 5'd10,
    K_DOWN      = 5'd11,
    K_KILLSTART = 5'd12,
    K_KILLEND   = 5'd13,
    K_KILLWORD  = 5'd14,
    K_CLEAR     = 5'd15,
    K_WORDLEFT  = 5'd16,
    K_WORDRIGHT = 5'd17,
    K_DELETE    = 5'd18,
    K_IGNORED   = 5'd19
  } key_code_t;

  // control bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ENQ = 8'h05;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_VT  = 8'h0B;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_SO  = 8'h0E;
  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_ETB = 8'h17;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_DEL = 8'h7F;

  // printable range and csi parameter range
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_PARAM_HI = 8'h3F;

  // utf-8 lead and continuation patterns
  localparam logic [7:0] MASK_2BIT  = 8'hC0;
  localparam logic [7:0] MASK_3BIT  = 8'hE0;
  localparam logic [7:0] MASK_4BIT  = 8'hF0;
  localparam logic [7:0] MASK_5BIT  = 8'hF8;
  localparam logic [7:0] TAG_CONT   = 8'h80;
  localparam logic [7:0] TAG_LEAD2  = 8'hC0;
  localparam logic [7:0] TAG_LEAD3  = 8'hE0;
  localparam logic [7:0] TAG_LEAD4  = 8'hF0;

  // sequence characters
  localparam logic [7:0] CHR_1        = 8'h31;
  localparam logic [7:0] CHR_3        = 8'h33;
  localparam logic [7:0] CHR_4        = 8'h34;
  localparam logic [7:0] CHR_5        = 8'h35;
  localparam logic [7:0] CHR_7        = 8'h37;
  localparam logic [7:0] CHR_8        = 8'h38;
  localparam logic [7:0] CHR_SEMI     = 8'h3B;
  localparam logic [7:0] CHR_A        = 8'h41;
  localparam logic [7:0] CHR_B        = 8'h42;
  localparam logic [7:0] CHR_C        = 8'h43;
  localparam logic [7:0] CHR_D        = 8'h44;
  localparam logic [7:0] CHR_F        = 8'h46;
  localparam logic [7:0] CHR_H        = 8'h48;
  localparam logic [7:0] CHR_O        = 8'h4F;
  localparam logic [7:0] CHR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHR_LC_B     = 8'h62;
  localparam logic [7:0] CHR_LC_F     = 8'h66;
  localparam logic [7:0] CHR_TILDE    = 8'h7E;

  localparam logic [3:0] TAB_MAX     = 4'd8;
  localparam logic [3:0] TAB_DEFAULT = 4'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    key_code_t   key_code;
    logic [63:0] text_bytes;
    logic [3:0]  text_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/tkbd_in_if.sv
// ----------------------------------------------------------------------------
// tkbd_in_if
// byte channel into the decoder, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tkbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tkbd_out_if.sv
// ----------------------------------------------------------------------------
// tkbd_out_if
// key event channel out of the decoder, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tkbd_out_if;
  logic                valid;
  logic                ready;
  tkbd_pkg::key_code_t key_code;
  logic [63:0]         text_bytes;
  logic [3:0]          text_length;

  modport source (output valid, output key_code, output text_bytes, output text_length,
                  input ready);
  modport sink   (input valid, input key_code, input text_bytes, input text_length,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/tkbd_in_stage.sv
// ----------------------------------------------------------------------------
// tkbd_in_stage
// input register: holds one byte until the decoder takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkbd_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  tkbd_in_if.sink             in_chan,
  input  wire logic           take,
  output tkbd_pkg::byte_item_t item
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       accept;

  // free when empty or being drained this cycle
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_chan.in_byte;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;

endmodule

`default_nettype wire

// File: rtl/core/tkbd_out_stage.sv
// ----------------------------------------------------------------------------
// tkbd_out_stage
// result register: holds one key event until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkbd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tkbd_pkg::result_t res,
  output logic                   out_free,
  tkbd_out_if.source             out_chan
);

  logic              valid_r;
  tkbd_pkg::result_t res_r;

  assign out_free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.key_code    = res_r.key_code;
  assign out_chan.text_bytes  = res_r.text_bytes;
  assign out_chan.text_length = res_r.text_length;

endmodule

`default_nettype wire

// File: rtl/core/tkbd_decode_core.sv
// ----------------------------------------------------------------------------
// tkbd_decode_core
// decode state machine: one byte in, one key event out per taken item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_key_byte_decoder_defines.svh"

module tkbd_decode_core #(
  parameter int PARAM_CAP = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tkbd_pkg::byte_item_t item,
  input  wire logic                 out_free,
  input  wire logic [3:0]           tab_width,
  output logic                      take,
  output tkbd_pkg::result_t         res
);

  localparam int PCW = $clog2(PARAM_CAP + 1);
  localparam logic [PCW-1:0] CAP_L = PCW'(PARAM_CAP);

  typedef enum logic [2:0] {
    M_GROUND = 3'd0,
    M_UTF8   = 3'd1,
    M_ESCAPE = 3'd2,
    M_CSI    = 3'd3,
    M_SS3    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    F_EMPTY = 3'd0,
    F_HOME  = 3'd1,
    F_END   = 3'd2,
    F_DEL   = 3'd3,
    F_OTHER = 3'd4
  } field_t;

  mode_t          mode_r,      mode_nxt;
  logic [23:0]    u8_data_r,   u8_data_nxt;
  logic [1:0]     u8_count_r,  u8_count_nxt;
  logic [1:0]     u8_owed_r,   u8_owed_nxt;
  logic [PCW-1:0] pc_r,        pc_nxt;
  logic           ctrl_mod_r,  ctrl_mod_nxt;
  logic           prev_semi_r, prev_semi_nxt;
  logic           semi_r,      semi_nxt;
  field_t         ffc_r,       ffc_nxt;

  logic [7:0]  b;
  logic        do_ground;
  logic [31:0] u8_word;
  logic [3:0]  tab_n;

  function automatic tkbd_pkg::key_code_t final_key(input logic [7:0] fb,
                                                    input logic ctrl_mod,
                                                    input field_t ffc);
    tkbd_pkg::key_code_t k;
    k = tkbd_pkg::K_IGNORED;
    unique case (fb)
      tkbd_pkg::CHR_A: k = tkbd_pkg::K_UP;
      tkbd_pkg::CHR_B: k = tkbd_pkg::K_DOWN;
      tkbd_pkg::CHR_C: k = ctrl_mod ? tkbd_pkg::K_WORDRIGHT : tkbd_pkg::K_RIGHT;
      tkbd_pkg::CHR_D: k = ctrl_mod ? tkbd_pkg::K_WORDLEFT : tkbd_pkg::K_LEFT;
      tkbd_pkg::CHR_H: k = tkbd_pkg::K_HOME;
      tkbd_pkg::CHR_F: k = tkbd_pkg::K_END;
      tkbd_pkg::CHR_TILDE: begin
        if (ffc == F_HOME) begin
          k = tkbd_pkg::K_HOME;
        end else if (ffc == F_END) begin
          k = tkbd_pkg::K_END;
        end else if (ffc == F_DEL) begin
          k = tkbd_pkg::K_DELETE;
        end
      end
      default: k = tkbd_pkg::K_IGNORED;
    endcase
    return k;
  endfunction

  assign take  = item.valid && out_free;
  assign b     = item.data;
  assign tab_n = (tab_width > tkbd_pkg::TAB_MAX) ? tkbd_pkg::TAB_MAX : tab_width;

  // collected bytes with the new byte placed after them
  assign u8_word = {8'd0, u8_data_r} | ({24'd0, b} << {u8_count_r, 3'b000});

  always_comb begin
    mode_nxt      = mode_r;
    u8_data_nxt   = u8_data_r;
    u8_count_nxt  = u8_count_r;
    u8_owed_nxt   = u8_owed_r;
    pc_nxt        = pc_r;
    ctrl_mod_nxt  = ctrl_mod_r;
    prev_semi_nxt = prev_semi_r;
    semi_nxt      = semi_r;
    ffc_nxt       = ffc_r;
    res.key_code    = tkbd_pkg::K_NONE;
    res.text_bytes  = 64'd0;
    res.text_length = 4'd0;
    do_ground     = 1'b0;

    if (take) begin
      unique case (mode_r)
        M_GROUND: do_ground = 1'b1;
        M_UTF8: begin
          if ((b & tkbd_pkg::MASK_2BIT) != tkbd_pkg::TAG_CONT) begin
            // truncated character: drop it and decode this byte fresh
            mode_nxt      = M_GROUND;
            u8_data_nxt   = 24'd0;
            u8_count_nxt  = 2'd0;
            u8_owed_nxt   = 2'd0;
            pc_nxt        = '0;
            ctrl_mod_nxt  = 1'b0;
            prev_semi_nxt = 1'b0;
            semi_nxt      = 1'b0;
            ffc_nxt       = F_EMPTY;
            do_ground     = 1'b1;
          end else if (u8_owed_r > 2'd1 && u8_count_r < 2'd3) begin
            u8_data_nxt  = u8_word[23:0];
            u8_count_nxt = u8_count_r + 2'd1;
            u8_owed_nxt  = u8_owed_r - 2'd1;
          end else begin
            res.key_code    = tkbd_pkg::K_CHAR;
            res.text_bytes  = {32'd0, u8_word};
            res.text_length = {2'b00, u8_count_r} + 4'd1;
            mode_nxt      = M_GROUND;
            u8_data_nxt   = 24'd0;
            u8_count_nxt  = 2'd0;
            u8_owed_nxt   = 2'd0;
            pc_nxt        = '0;
            ctrl_mod_nxt  = 1'b0;
            prev_semi_nxt = 1'b0;
            semi_nxt      = 1'b0;
            ffc_nxt       = F_EMPTY;
          end
        end
        M_ESCAPE: begin
          pc_nxt        = '0;
          ctrl_mod_nxt  = 1'b0;
          prev_semi_nxt = 1'b0;
          semi_nxt      = 1'b0;
          ffc_nxt       = F_EMPTY;
          if (b == tkbd_pkg::CHR_LBRACKET) begin
            mode_nxt = M_CSI;
          end else if (b == tkbd_pkg::CHR_O) begin
            mode_nxt = M_SS3;
          end else begin
            mode_nxt = M_GROUND;
            if (b == tkbd_pkg::CHR_LC_B || b == tkbd_pkg::CHR_B) begin
              res.key_code = tkbd_pkg::K_WORDLEFT;
            end else if (b == tkbd_pkg::CHR_LC_F || b == tkbd_pkg::CHR_F) begin
              res.key_code = tkbd_pkg::K_WORDRIGHT;
            end else begin
              res.key_code = tkbd_pkg::K_IGNORED;
            end
          end
        end
        M_CSI: begin
          if (b >= tkbd_pkg::BYTE_SPACE && b <= tkbd_pkg::BYTE_PARAM_HI) begin
            // parameter byte, dropped once the store is full
            if (pc_r < CAP_L) begin
              if (prev_semi_r && b == tkbd_pkg::CHR_5) begin
                ctrl_mod_nxt = 1'b1;
              end
              prev_semi_nxt = (b == tkbd_pkg::CHR_SEMI);
              if (b == tkbd_pkg::CHR_SEMI) begin
                semi_nxt = 1'b1;
              end else if (!semi_r) begin
                if (ffc_r != F_EMPTY) begin
                  ffc_nxt = F_OTHER;
                end else if (b == tkbd_pkg::CHR_1 || b == tkbd_pkg::CHR_7) begin
                  ffc_nxt = F_HOME;
                end else if (b == tkbd_pkg::CHR_4 || b == tkbd_pkg::CHR_8) begin
                  ffc_nxt = F_END;
                end else if (b == tkbd_pkg::CHR_3) begin
                  ffc_nxt = F_DEL;
                end else begin
                  ffc_nxt = F_OTHER;
                end
              end
              pc_nxt = pc_r + 1'b1;
            end
          end else begin
            mode_nxt     = M_GROUND;
            res.key_code = final_key(b, ctrl_mod_r, ffc_r);
          end
        end
        M_SS3: begin
          mode_nxt     = M_GROUND;
          res.key_code = final_key(b, ctrl_mod_r, ffc_r);
        end
        default: begin
          mode_nxt      = M_GROUND;
          u8_data_nxt   = 24'd0;
          u8_count_nxt  = 2'd0;
          u8_owed_nxt   = 2'd0;
          pc_nxt        = '0;
          ctrl_mod_nxt  = 1'b0;
          prev_semi_nxt = 1'b0;
          semi_nxt      = 1'b0;
          ffc_nxt       = F_EMPTY;
          res.key_code  = tkbd_pkg::K_IGNORED;
        end
      endcase

      if (do_ground) begin
        unique case (b) inside
          tkbd_pkg::BYTE_ESC: mode_nxt = M_ESCAPE;
          tkbd_pkg::BYTE_CR, tkbd_pkg::BYTE_LF: res.key_code = tkbd_pkg::K_ENTER;
          tkbd_pkg::BYTE_DEL, tkbd_pkg::BYTE_BS: res.key_code = tkbd_pkg::K_BACKSPACE;
          tkbd_pkg::BYTE_ETX: res.key_code = tkbd_pkg::K_INTERRUPT;
          tkbd_pkg::BYTE_EOT: res.key_code = tkbd_pkg::K_EOF;
          tkbd_pkg::BYTE_SOH: res.key_code = tkbd_pkg::K_HOME;
          tkbd_pkg::BYTE_ENQ: res.key_code = tkbd_pkg::K_END;
          tkbd_pkg::BYTE_STX: res.key_code = tkbd_pkg::K_LEFT;
          tkbd_pkg::BYTE_ACK: res.key_code = tkbd_pkg::K_RIGHT;
          tkbd_pkg::BYTE_DLE: res.key_code = tkbd_pkg::K_UP;
          tkbd_pkg::BYTE_SO:  res.key_code = tkbd_pkg::K_DOWN;
          tkbd_pkg::BYTE_NAK: res.key_code = tkbd_pkg::K_KILLSTART;
          tkbd_pkg::BYTE_VT:  res.key_code = tkbd_pkg::K_KILLEND;
          tkbd_pkg::BYTE_ETB: res.key_code = tkbd_pkg::K_KILLWORD;
          tkbd_pkg::BYTE_FF:  res.key_code = tkbd_pkg::K_CLEAR;
          tkbd_pkg::BYTE_TAB: begin
            res.key_code    = tkbd_pkg::K_CHAR;
            res.text_length = tab_n;
            for (int i = 0; i < 8; i++) begin
              if (4'(i) < tab_n) begin
                res.text_bytes[8*i +: 8] = tkbd_pkg::BYTE_SPACE;
              end
            end
          end
          default: begin
            if (b < tkbd_pkg::BYTE_SPACE) begin
              res.key_code = tkbd_pkg::K_IGNORED;
            end else if (!b[7]) begin
              res.key_code    = tkbd_pkg::K_CHAR;
              res.text_bytes  = {56'd0, b};
              res.text_length = 4'd1;
            end else if ((b & tkbd_pkg::MASK_3BIT) == tkbd_pkg::TAG_LEAD2 ||
                         (b & tkbd_pkg::MASK_4BIT) == tkbd_pkg::TAG_LEAD3 ||
                         (b & tkbd_pkg::MASK_5BIT) == tkbd_pkg::TAG_LEAD4) begin
              // multi-byte lead: start collecting
              mode_nxt     = M_UTF8;
              u8_data_nxt  = {16'd0, b};
              u8_count_nxt = 2'd1;
              if ((b & tkbd_pkg::MASK_3BIT) == tkbd_pkg::TAG_LEAD2) begin
                u8_owed_nxt = 2'd1;
              end else if ((b & tkbd_pkg::MASK_4BIT) == tkbd_pkg::TAG_LEAD3) begin
                u8_owed_nxt = 2'd2;
              end else begin
                u8_owed_nxt = 2'd3;
              end
            end else begin
              res.key_code = tkbd_pkg::K_IGNORED;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_GROUND;
      u8_data_r   <= 24'd0;
      u8_count_r  <= 2'd0;
      u8_owed_r   <= 2'd0;
      pc_r        <= '0;
      ctrl_mod_r  <= 1'b0;
      prev_semi_r <= 1'b0;
      semi_r      <= 1'b0;
      ffc_r       <= F_EMPTY;
    end else begin
      mode_r      <= mode_nxt;
      u8_data_r   <= u8_data_nxt;
      u8_count_r  <= u8_count_nxt;
      u8_owed_r   <= u8_owed_nxt;
      pc_r        <= pc_nxt;
      ctrl_mod_r  <= ctrl_mod_nxt;
      prev_semi_r <= prev_semi_nxt;
      semi_r      <= semi_nxt;
      ffc_r       <= ffc_nxt;
    end
  end

  `TKBD_ASSERT_ALWAYS(a_pc_cap, pc_r <= CAP_L, "csi parameter count beyond cap")
  `TKBD_ASSERT_IMPL(a_u8_idle, mode_r != M_UTF8, u8_count_r == 2'd0 && u8_owed_r == 2'd0, "utf8 trackers set outside utf8 mode")
  `TKBD_ASSERT_IMPL(a_u8_busy, mode_r == M_UTF8, u8_count_r != 2'd0 && u8_owed_r != 2'd0, "utf8 mode with empty trackers")
  `TKBD_ASSERT_NEXT(a_esc_leave, take && mode_r == M_ESCAPE, mode_r != M_ESCAPE, "escape mode held past its byte")

endmodule

`default_nettype wire

// File: rtl/core/terminal_key_byte_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_byte_decoder
// decodes a raw terminal byte stream into key events, one event per byte
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    in_byte[7:0]
//   out_chan  out   valid/ready    key_code[4:0], text_bytes[63:0], text_length[3:0]
//   cfg_*     in    write enable   cfg_wdata[3:0] -> tab_width
//
// one item per cycle sustained while the result register drains; each byte is held
// in the input register, is decoded by the mode state machine and lands in the result
// register, which offers it on out_chan until the sink takes it
// reset is synchronous, active low: decode mode to ground, trackers cleared,
// tab_width to 4
// a stalled result stays in the result register; the input register keeps
// taking bytes as long as the result register drains in the same cycle
//
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_byte_decoder #(
  parameter int PARAM_CAP = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  tkbd_in_if.sink         in_chan,
  tkbd_out_if.source      out_chan
);

  tkbd_pkg::byte_item_t item;
  tkbd_pkg::result_t    res;
  logic                 take;
  logic                 out_free;
  logic [3:0]           tab_width_r;

  // tab width register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= tkbd_pkg::TAB_DEFAULT;
    end else if (cfg_we) begin
      tab_width_r <= cfg_wdata;
    end
  end

  // byte held here until the decoder can move it on
  tkbd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .item    (item)
  );

  // mode state machine and key mapping
  tkbd_decode_core #(
    .PARAM_CAP (PARAM_CAP)
  ) u_decode_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .out_free  (out_free),
    .tab_width (tab_width_r),
    .take      (take),
    .res       (res)
  );

  // key event held here until the sink takes it
  tkbd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// terminal key byte decoder testbench
// drives raw terminal bytes through the decoder with random gaps on both
// channels, predicts every key event in a scoreboard and compares it field by
// field; tab width is changed between phases while the decoder is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tkbd_pkg::*;

  localparam int          PARAM_CAP    = 16;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          PHASE_ITEMS  = 125;
  localparam int unsigned TIMEOUT_NS   = 4_000_000;

  // decoder modes and first csi field classes, as the predictor tracks them
  typedef enum logic [2:0] {
    MODE_GROUND, MODE_UTF8, MODE_ESCAPE, MODE_CSI, MODE_SS3
  } decode_mode_t;

  typedef enum logic [2:0] {
    FIELD_EMPTY, FIELD_HOME, FIELD_END, FIELD_DELETE, FIELD_OTHER
  } field_class_t;

  // predicts the key event of every accepted byte and checks the decoder's events
  class key_scoreboard;
    logic [3:0]   tab_width;
    decode_mode_t mode;
    logic [23:0]  utf8_bytes;
    logic [1:0]   utf8_count;
    logic [1:0]   utf8_owed;
    int unsigned  param_count;
    bit           ctrl_modifier;
    bit           prev_semi;
    bit           semi_seen;
    field_class_t first_field;
    result_t      expected_keys[$];
    int unsigned  mismatches;

    function new();
      tab_width  = TAB_DEFAULT;
      mismatches = 0;
      clear_all();
    endfunction

    function void clear_params();
      param_count   = 0;
      ctrl_modifier = 0;
      prev_semi     = 0;
      semi_seen     = 0;
      first_field   = FIELD_EMPTY;
    endfunction

    function void clear_all();
      mode       = MODE_GROUND;
      utf8_bytes = '0;
      utf8_count = '0;
      utf8_owed  = '0;
      clear_params();
    endfunction

    function result_t make_event(key_code_t k, logic [63:0] t, logic [3:0] n);
      result_t r;
      r.key_code    = k;
      r.text_bytes  = t;
      r.text_length = n;
      return r;
    endfunction

    function int unsigned lead_length(logic [7:0] b);
      if (b < TAG_CONT) return 1;
      if ((b & MASK_3BIT) == TAG_LEAD2) return 2;
      if ((b & MASK_4BIT) == TAG_LEAD3) return 3;
      if ((b & MASK_5BIT) == TAG_LEAD4) return 4;
      return 0;
    endfunction

    function result_t decode_ground(logic [7:0] b);
      int unsigned n;
      int unsigned len;
      logic [63:0] spaces;
      spaces = '0;
      case (b)
        BYTE_ESC: begin
          mode = MODE_ESCAPE;
          return make_event(K_NONE, '0, '0);
        end
        BYTE_CR, BYTE_LF: return make_event(K_ENTER, '0, '0);
        BYTE_DEL, BYTE_BS: return make_event(K_BACKSPACE, '0, '0);
        BYTE_ETX: return make_event(K_INTERRUPT, '0, '0);
        BYTE_EOT: return make_event(K_EOF, '0, '0);
        BYTE_SOH: return make_event(K_HOME, '0, '0);
        BYTE_ENQ: return make_event(K_END, '0, '0);
        BYTE_STX: return make_event(K_LEFT, '0, '0);
        BYTE_ACK: return make_event(K_RIGHT, '0, '0);
        BYTE_DLE: return make_event(K_UP, '0, '0);
        BYTE_SO:  return make_event(K_DOWN, '0, '0);
        BYTE_NAK: return make_event(K_KILLSTART, '0, '0);
        BYTE_VT:  return make_event(K_KILLEND, '0, '0);
        BYTE_ETB: return make_event(K_KILLWORD, '0, '0);
        BYTE_FF:  return make_event(K_CLEAR, '0, '0);
        BYTE_TAB: begin
          // zero width gives an empty char, above eight saturates
          n = (tab_width > TAB_MAX) ? TAB_MAX : tab_width;
          for (int i = 0; i < n; i++) spaces[8*i +: 8] = BYTE_SPACE;
          return make_event(K_CHAR, spaces, 4'(n));
        end
        default: begin
          if (b < BYTE_SPACE) return make_event(K_IGNORED, '0, '0);
          len = lead_length(b);
          if (len == 0) return make_event(K_IGNORED, '0, '0);
          if (len == 1) return make_event(K_CHAR, {56'b0, b}, 4'd1);
          utf8_bytes = {16'b0, b};
          utf8_count = 2'd1;
          utf8_owed  = 2'(len - 1);
          mode       = MODE_UTF8;
          return make_event(K_NONE, '0, '0);
        end
      endcase
    endfunction

    function key_code_t seq_key(logic [7:0] b);
      case (b)
        CHR_A: return K_UP;
        CHR_B: return K_DOWN;
        CHR_C: begin
          if (ctrl_modifier) return K_WORDRIGHT;
          return K_RIGHT;
        end
        CHR_D: begin
          if (ctrl_modifier) return K_WORDLEFT;
          return K_LEFT;
        end
        CHR_H: return K_HOME;
        CHR_F: return K_END;
        CHR_TILDE: begin
          if (first_field == FIELD_HOME) return K_HOME;
          if (first_field == FIELD_END) return K_END;
          if (first_field == FIELD_DELETE) return K_DELETE;
          return K_IGNORED;
        end
        default: return K_IGNORED;
      endcase
    endfunction

    function void store_param(logic [7:0] b);
      if (prev_semi && b == CHR_5) ctrl_modifier = 1;
      prev_semi = (b == CHR_SEMI);
      if (b == CHR_SEMI) begin
        semi_seen = 1;
      end else if (!semi_seen) begin
        if (first_field != FIELD_EMPTY) first_field = FIELD_OTHER;
        else if (b == CHR_1 || b == CHR_7) first_field = FIELD_HOME;
        else if (b == CHR_4 || b == CHR_8) first_field = FIELD_END;
        else if (b == CHR_3) first_field = FIELD_DELETE;
        else first_field = FIELD_OTHER;
      end
      param_count++;
    endfunction

    // works out the key event of one accepted byte and queues it
    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [63:0] t;
      case (mode)
        MODE_GROUND: r = decode_ground(b);
        MODE_UTF8: begin
          if ((b & MASK_2BIT) != TAG_CONT) begin
            // truncated character: drop it and decode the byte afresh
            clear_all();
            r = decode_ground(b);
          end else if (utf8_owed > 1 && utf8_count < 3) begin
            utf8_bytes[8*utf8_count +: 8] = b;
            utf8_count++;
            utf8_owed--;
            r = make_event(K_NONE, '0, '0);
          end else begin
            t = {40'b0, utf8_bytes} | ({56'b0, b} << (8 * utf8_count));
            r = make_event(K_CHAR, t, {2'b0, utf8_count} + 4'd1);
            clear_all();
          end
        end
        MODE_ESCAPE: begin
          clear_params();
          if (b == CHR_LBRACKET) begin
            mode = MODE_CSI;
            r = make_event(K_NONE, '0, '0);
          end else if (b == CHR_O) begin
            mode = MODE_SS3;
            r = make_event(K_NONE, '0, '0);
          end else begin
            mode = MODE_GROUND;
            if (b == CHR_LC_B || b == CHR_B) r = make_event(K_WORDLEFT, '0, '0);
            else if (b == CHR_LC_F || b == CHR_F) r = make_event(K_WORDRIGHT, '0, '0);
            else r = make_event(K_IGNORED, '0, '0);
          end
        end
        MODE_CSI: begin
          if (b >= BYTE_SPACE && b <= BYTE_PARAM_HI) begin
            // bytes past the parameter cap are dropped
            if (param_count < PARAM_CAP) store_param(b);
            r = make_event(K_NONE, '0, '0);
          end else begin
            mode = MODE_GROUND;
            r = make_event(seq_key(b), '0, '0);
          end
        end
        MODE_SS3: begin
          mode = MODE_GROUND;
          r = make_event(seq_key(b), '0, '0);
        end
        default: begin
          clear_all();
          r = make_event(K_IGNORED, '0, '0);
        end
      endcase
      expected_keys.push_back(r);
    endfunction

    task report(string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_key(key_code_t k, logic [63:0] t, logic [3:0] n);
      result_t exp;
      if (expected_keys.size() == 0) begin
        report($sformatf("key event %0d with nothing expected", k));
        return;
      end
      exp = expected_keys.pop_front();
      if (k !== exp.key_code)
        report($sformatf("key_code got %0d expected %0d", k, exp.key_code));
      if (t !== exp.text_bytes)
        report($sformatf("text_bytes got %h expected %h", t, exp.text_bytes));
      if (n !== exp.text_length)
        report($sformatf("text_length got %0d expected %0d", n, exp.text_length));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  tkbd_in_if  in_chan ();
  tkbd_out_if out_chan ();

  key_scoreboard key_check = new();

  bit          quiet_tail    = 0;  // no idling on either side near the end
  bit          hold_request  = 0;  // asks the receiver for one long hold-off
  int unsigned bytes_sent    = 0;
  int unsigned control_pick  = 0;  // walks the control byte list in turn

  terminal_key_byte_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // both handshakes sampled at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) key_check.note_byte(in_chan.in_byte);
      if (out_chan.valid && out_chan.ready)
        key_check.check_key(out_chan.key_code, out_chan.text_bytes, out_chan.text_length);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offers one byte, maybe after an idle burst, and returns at its handshake
  task automatic send_byte(input logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering until every expected key event has come out
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (key_check.expected_keys.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [3:0] w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_check.tab_width = w;
  endtask

  // one random sequence: mostly well-formed keys with random content,
  // the rest lone bytes and broken sequences
  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned len;
    int unsigned nparams;
    logic [7:0]  lead;
    logic [7:0]  digit;
    logic [7:0]  seq_end;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);

    // final byte shared by csi and ss3 sequences
    case ($urandom_range(0, 10))
      0: seq_end = CHR_A;
      1: seq_end = CHR_B;
      2: seq_end = CHR_C;
      3: seq_end = CHR_D;
      4: seq_end = CHR_H;
      5: seq_end = CHR_F;
      6, 7, 8: seq_end = CHR_TILDE;
      9: seq_end = 8'($urandom_range(8'h40, 8'h7E));
      default: seq_end = 8'($urandom_range(0, 255));
    endcase

    // first parameter digit, biased toward home, end and delete
    case ($urandom_range(0, 5))
      0: digit = CHR_1;
      1: digit = CHR_7;
      2: digit = CHR_4;
      3: digit = CHR_8;
      4: digit = CHR_3;
      default: digit = 8'($urandom_range(8'h30, 8'h39));
    endcase

    if (kind < 35) begin
      // lone byte: anything, a tab, or the next editing control byte
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b = 8'($urandom_range(0, 255));
        4, 5: b = BYTE_TAB;
        default: begin
          case (control_pick % 16)
            0: b = BYTE_SOH;
            1: b = BYTE_STX;
            2: b = BYTE_ETX;
            3: b = BYTE_EOT;
            4: b = BYTE_ENQ;
            5: b = BYTE_ACK;
            6: b = BYTE_BS;
            7: b = BYTE_LF;
            8: b = BYTE_VT;
            9: b = BYTE_FF;
            10: b = BYTE_CR;
            11: b = BYTE_SO;
            12: b = BYTE_DLE;
            13: b = BYTE_NAK;
            14: b = BYTE_ETB;
            default: b = BYTE_DEL;
          endcase
          control_pick++;
        end
      endcase
      send_byte(b);
    end else if (kind < 55) begin
      // multibyte utf-8 character, sometimes cut short by a non-continuation byte
      len = $urandom_range(2, 4);
      if (len == 2) lead = {3'b110, 5'($urandom)};
      else if (len == 3) lead = {4'b1110, 4'($urandom)};
      else lead = {5'b11110, 3'($urandom)};
      send_byte(lead);
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          b = 8'($urandom_range(0, 8'hBF));
          if ((b & MASK_2BIT) == TAG_CONT) b = b | MASK_2BIT;
          send_byte(b);
          break;
        end
        send_byte({2'b10, 6'($urandom)});
      end
    end else if (kind < 80) begin
      // csi sequence
      send_byte(BYTE_ESC);
      send_byte(CHR_LBRACKET);
      case ($urandom_range(0, 5))
        0: ;
        1: send_byte(digit);
        2: begin
          send_byte(CHR_1);
          send_byte(CHR_SEMI);
          send_byte(CHR_5);
        end
        3: begin
          nparams = $urandom_range(1, 4);
          repeat (nparams) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_PARAM_HI)));
        end
        4: begin
          // runs from one short of the parameter cap to four bytes past it
          nparams = $urandom_range(PARAM_CAP - 1, PARAM_CAP + 4);
          send_byte(digit);
          repeat (nparams - 1) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_PARAM_HI)));
        end
        default: begin
          send_byte(digit);
          send_byte(CHR_SEMI);
          send_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h30, 8'h39)) : CHR_5);
        end
      endcase
      send_byte(seq_end);
    end else if (kind < 90) begin
      // ss3 sequence
      send_byte(BYTE_ESC);
      send_byte(CHR_O);
      send_byte(seq_end);
    end else begin
      // escape followed by a word motion letter or anything else
      send_byte(BYTE_ESC);
      case ($urandom_range(0, 4))
        0: send_byte(CHR_LC_B);
        1: send_byte(CHR_B);
        2: send_byte(CHR_LC_F);
        3: send_byte(CHR_F);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // main sequence
  initial begin
    // extremes, stray and invalid bytes, tab, plain char, 2-byte char,
    // a truncated 3-byte char, a 4-byte char, csi delete, ss3 home, alt-b
    logic [7:0] directed_bytes[$] = '{
      8'h00, 8'hFF, TAG_CONT, BYTE_DEL, BYTE_TAB, CHR_A,
      8'hC3, 8'hA9, 8'hE2, 8'h82, CHR_A,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      BYTE_ESC, CHR_LBRACKET, CHR_3, CHR_TILDE,
      BYTE_ESC, CHR_O, CHR_H,
      BYTE_ESC, CHR_LC_B
    };
    logic [3:0] tab_plan[6] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd9, 4'd0};
    int unsigned phase_goal;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset tab width
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // random phases, each under its own tab width
    tab_plan[5] = 4'($urandom_range(0, 15));
    foreach (tab_plan[p]) begin
      write_tab_width(tab_plan[p]);
      // receiver stalls long so the decoder fills and stops taking bytes
      if (p == 1) hold_request = 1;
      if (p == 5) quiet_tail = 1;
      phase_goal = directed_bytes.size() + (p + 1) * PHASE_ITEMS;
      while (bytes_sent < phase_goal) send_random_sequence();
    end

    wait_drained();
    if (key_check.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d key events still expected", key_check.expected_keys.size());
    $display("FAIL");
    $finish;
  end

endmodule
